[rtl/uer_pkg.sv]
package uer_pkg;

	localparam int MEDIAN_TAPS_DEF = 5;

	localparam int TIME_W = 32;
	localparam int SHORT_W = 16;
	localparam int DIST_W = 20;
	localparam int SAMPLE_W = 19;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [26:0] Q8_PER_US = 27'd1124;
	localparam logic signed [DIST_W-1:0] DIST_TIMEOUT = -20'sd256;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SAFETY_MARGIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SERVO_SETTLE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PING_SPACING = 3'd4;

	localparam logic [SHORT_W-1:0] MIN_PULSE_RST = 16'd150;
	localparam logic [SHORT_W-1:0] MAX_PULSE_RST = 16'd30000;
	localparam logic [SHORT_W-1:0] SAFETY_MARGIN_RST = 16'd2000;
	localparam logic [TIME_W-1:0] SERVO_SETTLE_RST = 32'd200000;
	localparam logic [TIME_W-1:0] PING_SPACING_RST = 32'd60000;

	typedef enum logic [1:0] {
		ACT_START = 2'd0,
		ACT_EDGE  = 2'd1,
		ACT_POLL  = 2'd2,
		ACT_SERVO = 2'd3
	} action_t;

	// The not-ready code also serves as the clean echo mark.
	typedef enum logic [1:0] {
		ST_NOT_READY = 2'd0,
		ST_OK        = 2'd1,
		ST_TIMEOUT   = 2'd2,
		ST_TOO_CLOSE = 2'd3
	} status_t;

	typedef struct packed {
		logic [SHORT_W-1:0] min_pulse_us;
		logic [SHORT_W-1:0] max_pulse_us;
		logic [SHORT_W-1:0] safety_margin_us;
		logic [TIME_W-1:0]  servo_settle_us;
		logic [TIME_W-1:0]  ping_spacing_us;
	} cfg_t;

	typedef struct packed {
		action_t           action;
		logic [TIME_W-1:0] now_us;
		logic [1:0]        edge_events;
		logic              is_echo_pin;
	} evt_t;

	typedef struct packed {
		status_t                  status;
		logic signed [DIST_W-1:0] distance_q8;
		logic                     update_done;
		logic                     fire_trigger;
		logic                     servo_settled;
		logic                     ping_spacing_ok;
	} res_t;

endpackage

[rtl/uer_if.sv]
interface uer_evt_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [31:0] now_us;
	logic [1:0]  edge_events;
	logic        is_echo_pin;

	modport source (output valid, action, now_us, edge_events, is_echo_pin, input ready);
	modport sink (input valid, action, now_us, edge_events, is_echo_pin, output ready);
endinterface

interface uer_res_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [19:0] distance_q8;
	logic               update_done;
	logic               fire_trigger;
	logic               servo_settled;
	logic               ping_spacing_ok;

	modport source (output valid, status, distance_q8, update_done, fire_trigger,
		servo_settled, ping_spacing_ok, input ready);
	modport sink (input valid, status, distance_q8, update_done, fire_trigger,
		servo_settled, ping_spacing_ok, output ready);
endinterface

[rtl/uer_cfg_regs.sv]
module uer_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           we,
	input  logic [uer_pkg::CFG_IDX_W-1:0]  index,
	input  logic [uer_pkg::CFG_DATA_W-1:0] wdata,
	output uer_pkg::cfg_t                  cfg
);
	import uer_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_pulse_us <= MIN_PULSE_RST;
			cfg_q.max_pulse_us <= MAX_PULSE_RST;
			cfg_q.safety_margin_us <= SAFETY_MARGIN_RST;
			cfg_q.servo_settle_us <= SERVO_SETTLE_RST;
			cfg_q.ping_spacing_us <= PING_SPACING_RST;
		end else if (we) begin
			case (index)
				REG_MIN_PULSE: cfg_q.min_pulse_us <= wdata[SHORT_W-1:0];
				REG_MAX_PULSE: cfg_q.max_pulse_us <= wdata[SHORT_W-1:0];
				REG_SAFETY_MARGIN: cfg_q.safety_margin_us <= wdata[SHORT_W-1:0];
				REG_SERVO_SETTLE: cfg_q.servo_settle_us <= wdata[TIME_W-1:0];
				REG_PING_SPACING: cfg_q.ping_spacing_us <= wdata[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

[rtl/uer_median.sv]
module uer_median #(
	parameter int MEDIAN_TAPS = uer_pkg::MEDIAN_TAPS_DEF
) (
	input  logic [uer_pkg::SAMPLE_W-1:0] samples [MEDIAN_TAPS],
	output logic [uer_pkg::SAMPLE_W-1:0] median
);
	import uer_pkg::*;

	localparam int RW = $clog2(MEDIAN_TAPS);
	localparam int MID = MEDIAN_TAPS / 2;

	logic [RW-1:0] rank [MEDIAN_TAPS];

	// Each sample's place in a stable sort; equal values rank by position.
	always_comb begin
		for (int i = 0; i < MEDIAN_TAPS; i++) begin
			rank[i] = '0;
			for (int j = 0; j < MEDIAN_TAPS; j++) begin
				if (j != i && ((samples[j] < samples[i]) ||
					(samples[j] == samples[i] && j < i))) begin
					rank[i] = rank[i] + RW'(1);
				end
			end
		end
	end

	always_comb begin
		median = '0;
		for (int i = 0; i < MEDIAN_TAPS; i++) begin
			if (rank[i] == RW'(MID)) begin
				median = samples[i];
			end
		end
	end
endmodule

[rtl/uer_core.sv]
module uer_core #(
	parameter int MEDIAN_TAPS = uer_pkg::MEDIAN_TAPS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          fire,
	input  uer_pkg::evt_t item,
	input  uer_pkg::cfg_t cfg,
	output uer_pkg::res_t result
);
	import uer_pkg::*;

	localparam int IDX_W = $clog2(MEDIAN_TAPS);

	logic [TIME_W-1:0]        rise_q, start_q, ping_q, servo_q;
	logic [SAMPLE_W-1:0]      dist_q;
	logic                     seen_q, measuring_q, full_q;
	status_t                  err_q, state_code_q;
	logic signed [DIST_W-1:0] last_dist_q;
	logic [SAMPLE_W-1:0]      ring_q [MEDIAN_TAPS];
	logic [IDX_W-1:0]         idx_q;

	logic [TIME_W-1:0]        rise_d, start_d, ping_d, servo_d;
	logic [SAMPLE_W-1:0]      dist_d;
	logic                     seen_d, measuring_d, full_d;
	status_t                  err_d, state_code_d;
	logic signed [DIST_W-1:0] last_dist_d;
	logic [IDX_W-1:0]         idx_d;
	logic                     ring_we;
	logic                     done;

	logic [SAMPLE_W-1:0]      ring_wr [MEDIAN_TAPS];
	logic [SAMPLE_W-1:0]      median;
	logic [TIME_W-1:0]        pulse;
	logic [26:0]              prod;
	logic [16:0]              limit;
	logic [TIME_W-1:0]        elapsed;

	always_comb begin
		for (int i = 0; i < MEDIAN_TAPS; i++) begin
			ring_wr[i] = (IDX_W'(i) == idx_q) ? dist_q : ring_q[i];
		end
	end

	uer_median #(.MEDIAN_TAPS(MEDIAN_TAPS)) u_median (
		.samples(ring_wr),
		.median (median)
	);

	assign limit = {1'b0, cfg.max_pulse_us} + {1'b0, cfg.safety_margin_us};
	assign elapsed = item.now_us - start_q;

	always_comb begin
		rise_d = rise_q;
		start_d = start_q;
		ping_d = ping_q;
		servo_d = servo_q;
		dist_d = dist_q;
		seen_d = seen_q;
		measuring_d = measuring_q;
		full_d = full_q;
		err_d = err_q;
		state_code_d = state_code_q;
		last_dist_d = last_dist_q;
		idx_d = idx_q;
		ring_we = 1'b0;
		done = 1'b0;
		pulse = '0;
		prod = '0;

		case (item.action)
			ACT_START: begin
				seen_d = 1'b0;
				err_d = ST_NOT_READY;
				start_d = item.now_us;
				ping_d = item.now_us;
				measuring_d = 1'b1;
				state_code_d = ST_NOT_READY;
			end
			ACT_EDGE: begin
				if (item.is_echo_pin) begin
					if (item.edge_events[0]) begin
						rise_d = item.now_us;
						seen_d = 1'b0;
						err_d = ST_NOT_READY;
					end
					if (item.edge_events[1]) begin
						seen_d = 1'b1;
						if (item.now_us <= rise_d) begin
							err_d = ST_TOO_CLOSE;
						end else begin
							pulse = item.now_us - rise_d;
							prod = pulse[26:0] * Q8_PER_US;
							dist_d = prod[26:8];
							if (pulse < {16'd0, cfg.min_pulse_us}) begin
								err_d = ST_TOO_CLOSE;
							end else if (pulse > {16'd0, cfg.max_pulse_us}) begin
								err_d = ST_TIMEOUT;
							end else begin
								err_d = ST_NOT_READY;
							end
						end
					end
				end
			end
			ACT_POLL: begin
				done = 1'b1;
				if (measuring_q) begin
					if (seen_q) begin
						measuring_d = 1'b0;
						case (err_q)
							ST_NOT_READY: begin
								ring_we = 1'b1;
								if (idx_q == IDX_W'(MEDIAN_TAPS - 1)) begin
									idx_d = '0;
									full_d = 1'b1;
								end else begin
									idx_d = idx_q + IDX_W'(1);
								end
								last_dist_d = $signed({1'b0, full_d ? median : dist_q});
								state_code_d = ST_OK;
							end
							ST_TIMEOUT: begin
								state_code_d = ST_TIMEOUT;
								last_dist_d = DIST_TIMEOUT;
							end
							default: begin
								state_code_d = ST_TOO_CLOSE;
								last_dist_d = '0;
							end
						endcase
					end else if (elapsed > {15'd0, limit}) begin
						measuring_d = 1'b0;
						state_code_d = ST_TIMEOUT;
						last_dist_d = DIST_TIMEOUT;
					end else begin
						done = 1'b0;
					end
				end
			end
			default: begin
				servo_d = item.now_us;
			end
		endcase

		result.status = state_code_d;
		result.distance_q8 = last_dist_d;
		result.update_done = done;
		result.fire_trigger = (item.action == ACT_START);
		result.servo_settled = (item.now_us - servo_d) >= cfg.servo_settle_us;
		result.ping_spacing_ok = (item.now_us - ping_d) >= cfg.ping_spacing_us;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_q <= '0;
			start_q <= '0;
			ping_q <= '0;
			servo_q <= '0;
			dist_q <= '0;
			seen_q <= 1'b0;
			measuring_q <= 1'b0;
			full_q <= 1'b0;
			err_q <= ST_NOT_READY;
			state_code_q <= ST_NOT_READY;
			last_dist_q <= DIST_TIMEOUT;
			idx_q <= '0;
			for (int i = 0; i < MEDIAN_TAPS; i++) begin
				ring_q[i] <= '0;
			end
		end else if (fire) begin
			rise_q <= rise_d;
			start_q <= start_d;
			ping_q <= ping_d;
			servo_q <= servo_d;
			dist_q <= dist_d;
			seen_q <= seen_d;
			measuring_q <= measuring_d;
			full_q <= full_d;
			err_q <= err_d;
			state_code_q <= state_code_d;
			last_dist_q <= last_dist_d;
			idx_q <= idx_d;
			if (ring_we) begin
				ring_q <= ring_wr;
			end
		end
	end
endmodule

[rtl/ultrasonic_echo_ranger_median.sv]
// Ultrasonic echo ranger with a median filter. Each request is one timestamped event
// (start, echo edge, poll, servo move) and yields exactly one result. A request is
// registered on acceptance, then handled by the state update logic, and its result
// sits in an output register; requests are taken one per cycle while the output side
// is free to accept a result. The distance in 1/256 cm is worked out when the falling
// edge arrives and enters a ring of MEDIAN_TAPS samples on the poll; once the ring has
// filled, the median of the ring is reported. The user is to write configuration
// registers through the plain write port only while no request is in flight; the
// block itself does not enforce this.
module ultrasonic_echo_ranger_median #(
	parameter int MEDIAN_TAPS = uer_pkg::MEDIAN_TAPS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	uer_evt_if.sink                        evt,
	uer_res_if.source                      res,
	input  logic                           cfg_we,
	input  logic [uer_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [uer_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import uer_pkg::*;

	cfg_t cfg;
	evt_t item_s1;
	logic s1_valid;
	logic s1_fire;
	res_t core_res;
	res_t res_q;
	logic res_valid_q;

	uer_cfg_regs u_cfg (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (cfg_we),
		.index (cfg_index),
		.wdata (cfg_wdata),
		.cfg   (cfg)
	);

	assign s1_fire = s1_valid && (!res_valid_q || res.ready);
	assign evt.ready = !s1_valid || s1_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (evt.ready) begin
				s1_valid <= evt.valid;
			end
			if (s1_fire) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			item_s1.action <= action_t'(evt.action);
			item_s1.now_us <= evt.now_us;
			item_s1.edge_events <= evt.edge_events;
			item_s1.is_echo_pin <= evt.is_echo_pin;
		end
		if (s1_fire) begin
			res_q <= core_res;
		end
	end

	uer_core #(.MEDIAN_TAPS(MEDIAN_TAPS)) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (s1_fire),
		.item  (item_s1),
		.cfg   (cfg),
		.result(core_res)
	);

	assign res.valid = res_valid_q;
	assign res.status = res_q.status;
	assign res.distance_q8 = res_q.distance_q8;
	assign res.update_done = res_q.update_done;
	assign res.fire_trigger = res_q.fire_trigger;
	assign res.servo_settled = res_q.servo_settled;
	assign res.ping_spacing_ok = res_q.ping_spacing_ok;
endmodule

[rtl/uer_checker.sv]
module uer_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               res_valid,
	input logic               res_ready,
	input logic [1:0]         status,
	input logic signed [19:0] distance_q8,
	input logic               update_done,
	input logic               fire_trigger
);
	import uer_pkg::*;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(status) &&
		$stable(distance_q8) && $stable(update_done) && $stable(fire_trigger))
		else $error("result changed while stalled");

	a_start_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && fire_trigger |-> status == ST_NOT_READY && !update_done)
		else $error("start result must be not ready and not done");

	a_timeout_dist: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == ST_TIMEOUT |-> distance_q8 == DIST_TIMEOUT)
		else $error("timeout result with wrong distance");

	a_close_dist: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == ST_TOO_CLOSE |-> distance_q8 == 20'sd0)
		else $error("too close result with nonzero distance");
endmodule

bind ultrasonic_echo_ranger_median uer_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.status      (res.status),
	.distance_q8 (res.distance_q8),
	.update_done (res.update_done),
	.fire_trigger(res.fire_trigger)
);
